FILE: src/binary_to_decimal_ascii_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII core
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Clocked assertion, inactive while reset is held.
`define B2D_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Clocked assertion, also checked across reset.
`define B2D_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

FILE: src/b2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_pkg
// Types and constants shared by the binary to decimal ASCII core.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int BinW      = 64;
    localparam int Digits    = 20;
    localparam int BcdW      = 4 * Digits;
    localparam int CntW      = 6;
    localparam int CharW     = 6;

    localparam logic [CntW-1:0]  LastShift = 6'd63;
    localparam logic [CntW-1:0]  LastDigit = 6'd19;
    localparam logic [CharW-1:0] AsciiZero = 6'd48;
    localparam logic [3:0]       BcdAdjMin = 4'd5;
    localparam logic [3:0]       BcdAdj    = 4'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic skip;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic shift_last;
        logic top_zero;
        logic started;
        logic last_pos;
        logic out_free;
    } t_sts;

endpackage

FILE: src/b2d_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_dpath
// Double-dabble datapath: operand and BCD shift registers, digit counter
// and the output transaction register.
// ----------------------------------------------------------------------------
module b2d_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  b2d_pkg::t_cmd                i_cmd,
    output b2d_pkg::t_sts                o_sts,
    input  logic [b2d_pkg::BinW-1:0]     i_value_bits,
    input  logic                         i_mode,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [b2d_pkg::CharW-1:0]    o_digit_char,
    output logic                         o_negative,
    output logic                         o_last
);

    logic [b2d_pkg::BinW-1:0]  r_bin, n_bin;
    logic [b2d_pkg::BcdW-1:0]  r_bcd, n_bcd;
    logic [b2d_pkg::CntW-1:0]  r_cnt, n_cnt;
    logic                      r_neg, n_neg;
    logic                      r_started, n_started;
    logic                      r_ovalid, n_ovalid;
    logic [b2d_pkg::CharW-1:0] r_char, n_char;
    logic                      r_oneg, n_oneg;
    logic                      r_olast, n_olast;

    logic [b2d_pkg::BcdW-1:0]  w_bcd_adj;
    logic [3:0]                w_top;
    logic                      w_in_neg;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < b2d_pkg::Digits; i++) begin
            if (r_bcd[i*4 +: 4] >= b2d_pkg::BcdAdjMin) begin
                w_bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + b2d_pkg::BcdAdj;
            end else begin
                w_bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    assign w_top    = r_bcd[b2d_pkg::BcdW-1 -: 4];
    assign w_in_neg = !i_mode && i_value_bits[b2d_pkg::BinW-1];

    always_comb begin
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_started = r_started;
        n_char    = r_char;
        n_oneg    = r_oneg;
        n_olast   = r_olast;
        n_ovalid  = i_out_ready ? 1'b0 : r_ovalid;
        if (i_cmd.load) begin
            n_bin     = w_in_neg ? (~i_value_bits + 64'd1) : i_value_bits;
            n_neg     = w_in_neg;
            n_bcd     = '0;
            n_cnt     = '0;
            n_started = 1'b0;
        end
        if (i_cmd.shift) begin
            n_bcd = {w_bcd_adj[b2d_pkg::BcdW-2:0], r_bin[b2d_pkg::BinW-1]};
            n_bin = {r_bin[b2d_pkg::BinW-2:0], 1'b0};
            n_cnt = r_cnt + 6'd1;
        end
        if (i_cmd.skip || i_cmd.emit) begin
            n_bcd = {r_bcd[b2d_pkg::BcdW-5:0], 4'd0};
            n_cnt = r_cnt + 6'd1;
        end
        if (i_cmd.emit) begin
            n_started = 1'b1;
            n_ovalid  = 1'b1;
            n_char    = b2d_pkg::AsciiZero + {2'b00, w_top};
            n_oneg    = r_neg;
            n_olast   = (r_cnt == b2d_pkg::LastDigit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_started <= n_started;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_neg   <= n_neg;
        r_char  <= n_char;
        r_oneg  <= n_oneg;
        r_olast <= n_olast;
    end

    assign o_sts.shift_last = (r_cnt == b2d_pkg::LastShift);
    assign o_sts.top_zero   = (w_top == 4'd0);
    assign o_sts.started    = r_started;
    assign o_sts.last_pos   = (r_cnt == b2d_pkg::LastDigit);
    assign o_sts.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid  = r_ovalid;
    assign o_digit_char = r_char;
    assign o_negative   = r_oneg;
    assign o_last       = r_olast;

endmodule

FILE: src/b2d_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_ctrl
// Sequencer: takes an operand, runs the shift phase, then drops leading
// zero digits and emits the rest one per free output slot.
// ----------------------------------------------------------------------------
module b2d_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  b2d_pkg::t_sts i_sts,
    output b2d_pkg::t_cmd o_cmd
);

    b2d_pkg::t_state r_state, n_state;
    logic            w_skip;

    // leading zero, not the units digit
    assign w_skip = i_sts.top_zero && !i_sts.started && !i_sts.last_pos;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            b2d_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = b2d_pkg::S_CONV;
                end
            end
            b2d_pkg::S_CONV: begin
                if (i_sts.shift_last) begin
                    n_state = b2d_pkg::S_EMIT;
                end
            end
            b2d_pkg::S_EMIT: begin
                if (!w_skip && i_sts.out_free && i_sts.last_pos) begin
                    n_state = b2d_pkg::S_IDLE;
                end
            end
            default: n_state = b2d_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            b2d_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            b2d_pkg::S_CONV: begin
                o_cmd.shift = 1'b1;
            end
            b2d_pkg::S_EMIT: begin
                o_cmd.skip = w_skip;
                o_cmd.emit = !w_skip && i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2d_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/binary_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// Sequence per operand: accept, the 64 double-dabble shift steps, then 20 digit positions,
//   where dropped leading zeros are skipped and output stalls hold back an emit.
// A new operand is taken only once the final digit of the previous one has been issued.
//   Each shift step moves a single operand bit through the double-dabble loop.
// Reset: synchronous, active low; returns to idle and drops any pending digit.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// 64-bit signed/unsigned binary to decimal ASCII digit stream, MSD first.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value_bits
    input  logic [0:0]  s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] digit_char, [7:6] zero
    output logic [0:0]  m_axis_tuser,   // [0] negative
    output logic        m_axis_tlast
);

    b2d_pkg::t_cmd              w_cmd;
    b2d_pkg::t_sts              w_sts;
    logic [b2d_pkg::CharW-1:0]  w_char;

    b2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    b2d_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_value_bits (s_axis_tdata),
        .i_mode       (s_axis_tuser[0]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_digit_char (w_char),
        .o_negative   (m_axis_tuser[0]),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_char};

endmodule

FILE: src/b2d_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_chk
// Port-level checker for the binary to decimal ASCII core.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_core_assert.svh"

module b2d_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic       w_in_acc;
    logic       w_out_stall;
    logic [9:0] w_out_bits;
    logic       w_digit_ok;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_out_bits  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign w_digit_ok  = (m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd57);

    // hold a stalled transaction
    `B2D_ASSERT_RST(a_out_hold, i_clk, i_rst_n, w_out_stall |=> m_axis_tvalid && $stable(w_out_bits))
    // digits only, upper bits zero
    `B2D_ASSERT_RST(a_digit_range, i_clk, i_rst_n, m_axis_tvalid |-> w_digit_ok)
    // one operand at a time
    `B2D_ASSERT_RST(a_busy_after_acc, i_clk, i_rst_n, w_in_acc |=> !s_axis_tready)
    // while taking operands, only the final digit of a run may still wait
    `B2D_ASSERT_RST(a_idle_pending_last, i_clk, i_rst_n, s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    // no digit pending after reset
    `B2D_ASSERT_ALL(a_reset_clear, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind binary_to_decimal_ascii_core b2d_chk u_b2d_chk (.*);
